// ----- rtl/core/stick_radial_soft_cap_assert.svh -----
// assertion macros used by stick_radial_soft_cap.sv
`ifndef STICK_RADIAL_SOFT_CAP_ASSERT_SVH
`define STICK_RADIAL_SOFT_CAP_ASSERT_SVH

// same-cycle implication on i_clk, quiet while i_rst_n is low
`define SRSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srsc assertion failed");

// next-cycle implication on i_clk, quiet while i_rst_n is low
`define SRSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srsc assertion failed");

`endif

// ----- rtl/core/srsc_pkg.sv -----
package srsc_pkg;

    localparam int XW         = 16;
    localparam int CAP_W      = 25;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 48;
    localparam int CSQ_W      = 50;
    localparam int MAG_W      = 24;
    localparam int PROD_W     = 41;
    localparam int NUM_W      = 42;
    localparam int DEN_W      = 25;
    localparam int Q_W        = 17;
    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 17;

    // one slot of the square root chain
    typedef struct packed {
        logic                 valid;
        logic                 apply;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [PROD_W-1:0]    px;
        logic [PROD_W-1:0]    py;
        logic [SQ_W-1:0]      rem;
        logic [SQ_W-1:0]      root;
    } t_sqrt;

    // one slot of the divide chain, both axes share the divisor
    typedef struct packed {
        logic                 valid;
        logic                 apply;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [DEN_W-1:0]     d;
        logic [NUM_W-1:0]     rx;
        logic [NUM_W-1:0]     ry;
        logic [Q_W-1:0]       qx;
        logic [Q_W-1:0]       qy;
    } t_div;

endpackage

// ----- rtl/core/stick_radial_soft_cap.sv -----
// radial soft cap for one stick sample pair. a beat on the input channel carries
// x and y; one beat comes out per input beat, in order. the block takes one beat per
// cycle while o_stall is low: the work runs down a fixed chain of cells (three front
// stages for squares and cap products, 24 root cells giving one root bit each, a
// numerator stage, 17 divide cells giving one quotient bit each, then the output
// register). a two-deep output (register plus skid) lets one more beat in while a
// finished beat waits; o_stall rises only when the skid is holding. cap_percent is to
// be written through the config channel while no beat is in flight; the block does
// not enforce this. zero passes samples through unchanged, otherwise vectors longer
// than FULL_SCALE * cap_percent / 100 are scaled back to that radius, rounded half
// away from zero and saturated to 16 bits.
module stick_radial_soft_cap #(
    parameter int FULL_SCALE = 32767
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [7:0]                    i_cfg_data,
    // sample input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [srsc_pkg::XW-1:0] i_x_in,
    input  logic signed [srsc_pkg::XW-1:0] i_y_in,
    // capped output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [srsc_pkg::XW-1:0] o_x_out,
    output logic signed [srsc_pkg::XW-1:0] o_y_out
);
    import srsc_pkg::*;

    `include "stick_radial_soft_cap_assert.svh"

    localparam longint PctScale = 100;
    localparam longint PctRound = 50;
    localparam int     PctCodes = 256;
    localparam logic signed [XW-1:0] SatHi = {1'b0, {(XW-1){1'b1}}};

    typedef logic [CAP_W-1:0] t_cap_tab [PctCodes];

    // cap radius with 8 fraction bits for every percent code, rounded half up
    function automatic t_cap_tab f_cap_tab();
        t_cap_tab tab;
        for (int i = 0; i < PctCodes; i++) begin
            tab[i] = CAP_W'((longint'(FULL_SCALE) * longint'(i) * 256 + PctRound) / PctScale);
        end
        return tab;
    endfunction

    localparam t_cap_tab CapTab = f_cap_tab();

    // restore sign, saturate; pass through when the cap does not apply
    function automatic logic signed [XW-1:0] f_axis(
        input logic signed [XW-1:0] v,
        input logic                 apply,
        input logic [Q_W-1:0]       q
    );
        logic signed [Q_W:0] mag;
        logic signed [Q_W:0] sv;
        mag = $signed({1'b0, q});
        sv  = v[XW-1] ? -mag : mag;
        if (!apply) begin
            return v;
        end else if (sv > (Q_W+1)'(SatHi)) begin
            return SatHi;
        end else begin
            return sv[XW-1:0];
        end
    endfunction

    function automatic logic [SUM_W-1:0] ax_sq(input logic signed [XW-1:0] v);
        logic [XW-1:0] a;
        a = v[XW-1] ? XW'(~v + 1'b1) : XW'(v);
        return SUM_W'(a) * SUM_W'(a);
    endfunction

    // config: cap radius and its square
    logic [CAP_W-1:0] r_cap_q8;
    logic [CSQ_W-1:0] r_cap_sq;

    // pipeline advance, frozen only while the skid holds a beat
    logic en;

    // front stages
    logic                 r_s1_v;
    logic signed [XW-1:0] r_s1_x, r_s1_y;
    logic                 r_s2_v;
    logic signed [XW-1:0] r_s2_x, r_s2_y;
    logic [XW-1:0]        r_s2_ax, r_s2_ay;
    logic [SUM_W-1:0]     r_s2_xx, r_s2_yy;
    logic                 r_s3_v;
    logic signed [XW-1:0] r_s3_x, r_s3_y;
    logic [SUM_W-1:0]     r_s3_sum;
    logic [PROD_W-1:0]    r_s3_px, r_s3_py;

    logic [SQ_W-1:0] s16;

    t_sqrt sq [SQRT_STEPS+1];
    t_div  dv [DIV_STEPS+1];
    t_div  n_dv0;
    t_div  r_dv0;

    // output register and skid
    logic                 r_ov, r_skid_v;
    logic signed [XW-1:0] r_ox, r_oy, r_kx, r_ky;
    logic signed [XW-1:0] res_x, res_y;
    logic                 res_v, take;
    logic                 quot_ok;

    assign o_cfg_ready = 1'b1;
    assign en          = !r_skid_v;
    assign o_stall     = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_q8 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap_q8 <= CapTab[i_cfg_data];
        end
    end

    // settles long before any beat reaches the compare
    always_ff @(posedge i_clk) begin
        r_cap_sq <= CSQ_W'(r_cap_q8) * CSQ_W'(r_cap_q8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // stage 1 takes the beat, stage 2 squares, stage 3 sums and cap products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x   <= i_x_in;
            r_s1_y   <= i_y_in;
            r_s2_x   <= r_s1_x;
            r_s2_y   <= r_s1_y;
            r_s2_ax  <= r_s1_x[XW-1] ? XW'(~r_s1_x + 1'b1) : XW'(r_s1_x);
            r_s2_ay  <= r_s1_y[XW-1] ? XW'(~r_s1_y + 1'b1) : XW'(r_s1_y);
            r_s2_xx  <= SUM_W'(ax_sq(r_s1_x));
            r_s2_yy  <= SUM_W'(ax_sq(r_s1_y));
            r_s3_x   <= r_s2_x;
            r_s3_y   <= r_s2_y;
            r_s3_sum <= r_s2_xx + r_s2_yy;
            r_s3_px  <= PROD_W'(r_s2_ax) * PROD_W'(r_cap_q8);
            r_s3_py  <= PROD_W'(r_s2_ay) * PROD_W'(r_cap_q8);
        end
    end

    // root chain entry: length compare against the cap, exact in squares
    assign s16 = {r_s3_sum, 16'b0};

    always_comb begin
        sq[0].valid = r_s3_v;
        sq[0].apply = (r_cap_q8 != '0) && (CSQ_W'(s16) > r_cap_sq);
        sq[0].x     = r_s3_x;
        sq[0].y     = r_s3_y;
        sq[0].px    = r_s3_px;
        sq[0].py    = r_s3_py;
        sq[0].rem   = s16;
        sq[0].root  = '0;
    end

    for (genvar i = 1; i <= SQRT_STEPS; i++) begin : g_sqrt
        srsc_sqrt_cell #(
            .BitPos (SQ_W - 2 * i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (sq[i-1]),
            .o_cell  (sq[i])
        );
    end

    // numerator 2*a*cap + mag over divisor 2*mag gives round half up
    always_comb begin
        n_dv0.valid = sq[SQRT_STEPS].valid;
        n_dv0.apply = sq[SQRT_STEPS].apply;
        n_dv0.x     = sq[SQRT_STEPS].x;
        n_dv0.y     = sq[SQRT_STEPS].y;
        n_dv0.d     = {sq[SQRT_STEPS].root[MAG_W-1:0], 1'b0};
        n_dv0.rx    = {sq[SQRT_STEPS].px, 1'b0} + NUM_W'(sq[SQRT_STEPS].root[MAG_W-1:0]);
        n_dv0.ry    = {sq[SQRT_STEPS].py, 1'b0} + NUM_W'(sq[SQRT_STEPS].root[MAG_W-1:0]);
        n_dv0.qx    = '0;
        n_dv0.qy    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0.valid <= 1'b0;
        end else if (en) begin
            r_dv0 <= n_dv0;
        end
    end

    assign dv[0] = r_dv0;

    // quotient never exceeds the axis magnitude, so 17 bits suffice
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        srsc_div_cell #(
            .Shift (DIV_STEPS - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (dv[k-1]),
            .o_cell  (dv[k])
        );
    end

    assign res_v = dv[DIV_STEPS].valid;
    assign res_x = f_axis(dv[DIV_STEPS].x, dv[DIV_STEPS].apply, dv[DIV_STEPS].qx);
    assign res_y = f_axis(dv[DIV_STEPS].y, dv[DIV_STEPS].apply, dv[DIV_STEPS].qy);
    assign take  = r_ov && !i_stall;

    // output register with one skid slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (res_v) begin
            if (r_ov && !take) begin
                r_skid_v <= 1'b1;
            end
            r_ov <= 1'b1;
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_ox <= r_kx;
                r_oy <= r_ky;
            end
        end else if (res_v) begin
            if (r_ov && !take) begin
                r_kx <= res_x;
                r_ky <= res_y;
            end else begin
                r_ox <= res_x;
                r_oy <= res_y;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_x_out = r_ox;
    assign o_y_out = r_oy;

    // scaled magnitudes stay within one past the positive 16-bit limit
    assign quot_ok = (dv[DIV_STEPS].qx <= Q_W'(32768)) && (dv[DIV_STEPS].qy <= Q_W'(32768));

    `SRSC_ASSERT_NOW(a_skid_behind_out, r_skid_v, r_ov)
    `SRSC_ASSERT_NOW(a_quot_bound, res_v && dv[DIV_STEPS].apply, quot_ok)
    `SRSC_ASSERT_NEXT(a_skid_fills, !r_skid_v && res_v && r_ov && i_stall, r_skid_v)

endmodule

// ----- rtl/core/srsc_sqrt_cell.sv -----
module srsc_sqrt_cell #(
    parameter int BitPos = 46
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  srsc_pkg::t_sqrt i_cell,
    output srsc_pkg::t_sqrt o_cell
);
    import srsc_pkg::*;

    localparam logic [SQ_W-1:0] StepBit = SQ_W'(1) << BitPos;

    logic [SQ_W-1:0] trial;
    t_sqrt           n_cell;
    t_sqrt           r_cell;

    // one digit of the restoring root
    always_comb begin
        n_cell = i_cell;
        trial  = i_cell.root + StepBit;
        if (i_cell.rem >= trial) begin
            n_cell.rem  = i_cell.rem - trial;
            n_cell.root = (i_cell.root >> 1) + StepBit;
        end else begin
            n_cell.root = i_cell.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ----- rtl/core/srsc_div_cell.sv -----
module srsc_div_cell #(
    parameter int Shift = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  srsc_pkg::t_div i_cell,
    output srsc_pkg::t_div o_cell
);
    import srsc_pkg::*;

    logic [NUM_W-1:0] dsh;
    t_div             n_cell;
    t_div             r_cell;

    // one quotient bit per axis
    always_comb begin
        n_cell = i_cell;
        dsh    = NUM_W'(i_cell.d) << Shift;
        if (i_cell.rx >= dsh) begin
            n_cell.rx        = i_cell.rx - dsh;
            n_cell.qx[Shift] = 1'b1;
        end
        if (i_cell.ry >= dsh) begin
            n_cell.ry        = i_cell.ry - dsh;
            n_cell.qy[Shift] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ----- tb/sv/stick_radial_soft_cap_tb.sv -----
module stick_radial_soft_cap_tb;

    localparam int FULL_SCALE = 32767;
    localparam int LATENCY    = 45;
    localparam int IDLE_LIMIT = 20000;

    // expected output pair
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_pair;

    // scoreboard: predicts capped pairs and checks them in order
    class cap_scoreboard;
        logic [7:0] cap_pct;
        t_pair      pending[$];
        int         errors;

        function new();
            cap_pct = 8'd0;
            errors  = 0;
        endfunction

        // exact integer square root, floor
        function automatic longint unsigned int_sqrt(longint unsigned n);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= root + bitv) begin
                    n    = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        // scale one axis by cap/mag, round half away from zero, saturate
        function automatic logic signed [15:0] scale_axis(longint v, longint unsigned cap_q8,
                                                          longint unsigned mag_q8);
            longint unsigned a;
            longint unsigned q;
            longint r;
            if (mag_q8 == 0) return 16'sd0;
            a = (v < 0) ? -v : v;
            q = (2 * a * cap_q8 + mag_q8) / (2 * mag_q8);
            r = (v < 0) ? -longint'(q) : longint'(q);
            if (r < -32768) r = -32768;
            if (r > 32767) r = 32767;
            return r[15:0];
        endfunction

        function automatic void note_sample(logic signed [15:0] xi, logic signed [15:0] yi);
            t_pair p;
            longint x, y;
            longint unsigned cap_q8, s16, mag_q8;
            x = xi;
            y = yi;
            p.x = xi;
            p.y = yi;
            if (cap_pct != 0) begin
                cap_q8 = (longint'(FULL_SCALE) * cap_pct * 256 + 50) / 100;
                s16    = longint'(x * x + y * y) << 16;
                if (s16 > cap_q8 * cap_q8) begin
                    mag_q8 = int_sqrt(s16);
                    p.x = scale_axis(x, cap_q8, mag_q8);
                    p.y = scale_axis(y, cap_q8, mag_q8);
                end
            end
            pending.push_back(p);
        endfunction

        function automatic void check_result(logic signed [15:0] xo, logic signed [15:0] yo);
            t_pair p;
            if (pending.size() == 0) begin
                $error("unexpected output beat x_out=%0d y_out=%0d", xo, yo);
                errors++;
                return;
            end
            p = pending.pop_front();
            if (xo !== p.x) begin
                $error("x_out expected %0d actual %0d", p.x, xo);
                errors++;
            end
            if (yo !== p.y) begin
                $error("y_out expected %0d actual %0d", p.y, yo);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_x_in;
    logic signed [15:0] i_y_in;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_x_out;
    logic signed [15:0] o_y_out;

    cap_scoreboard sb;
    int            idle_cycles;
    int            stall_mode;
    bit            running;

    stick_radial_soft_cap #(.FULL_SCALE(FULL_SCALE)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_x_in     (i_x_in),
        .i_y_in     (i_y_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_x_out    (o_x_out),
        .o_y_out    (o_y_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // output side: check every accepted beat, stall on a changing pattern
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(o_x_out, o_y_out);
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // watchdog: cycles with no beat accepted on any channel
    always @(posedge i_clk) begin
        if (running) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // burst state for the sender
    int burst_left;

    // send one sample, with bursts and random gaps ahead of it
    task automatic send_sample(logic signed [15:0] xv, logic signed [15:0] yv);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        i_valid <= 1'b1;
        i_x_in  <= xv;
        i_y_in  <= yv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_sample(xv, yv);
        burst_left--;
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
        i_x_in  <= 16'($urandom);
        i_y_in  <= 16'($urandom);
        burst_left = 0;
    endtask

    // wait until all results are back plus pipeline depth
    task automatic drain();
        stop_sending();
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_cap(logic [7:0] pct);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= pct;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.cap_pct = pct;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random vector biased around the cap radius for the current setting
    task automatic send_random();
        int r;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            send_sample(16'($urandom), 16'($urandom));
        end else if (mode < 7) begin
            // near an axis or a diagonal at a radius close to the cap
            r = (FULL_SCALE * sb.cap_pct) / 100 + $urandom_range(0, 40) - 20;
            if (r > 32767) r = 32767;
            if (r < 0) r = 0;
            case ($urandom_range(0, 3))
                0: send_sample(16'(r), 16'($urandom_range(0, 7) - 4));
                1: send_sample(16'($urandom_range(0, 7) - 4), 16'(-r));
                2: send_sample(16'((r * 181) / 256), 16'(-(r * 181) / 256));
                default: send_sample(16'(-r), 16'((r * 181) / 256));
            endcase
        end else if (mode < 9) begin
            send_sample(16'($urandom_range(0, 2000) - 1000), 16'($urandom_range(0, 2000) - 1000));
        end else begin
            send_sample($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000,
                        $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
        end
    endtask

    logic [7:0] caps[9];

    initial begin
        sb          = new();
        running     = 1'b0;
        idle_cycles = 0;
        stall_mode  = 0;
        burst_left  = 0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 8'd0;
        i_valid     = 1'b0;
        i_x_in      = 16'sd0;
        i_y_in      = 16'sd0;
        i_stall     = 1'b0;
        caps = '{8'd0, 8'd100, 8'd50, 8'd1, 8'd255, 8'd101, 8'd75, 8'd99, 8'd0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;
        @(posedge i_clk);

        // directed: cap disabled at reset, extremes pass through
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sh7fff);
        drain();

        // directed: cap at 50 percent, inside, on the edge, outside, zero length
        write_cap(8'd50);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd16383, 16'sd0);
        send_sample(16'sd16384, 16'sd0);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sd1000, -16'sd1000);
        send_sample(16'sh8000, 16'sd0);
        drain();

        // directed: cap above full scale, no vector is long enough to be scaled
        write_cap(8'd255);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sd0);
        drain();
        write_cap(8'd1);
        send_sample(16'sd327, 16'sd1);
        send_sample(-16'sd400, 16'sd3);
        send_sample(16'sh8000, 16'sh7fff);
        drain();

        // random phases over several cap settings and stall patterns
        for (int ph = 0; ph < 9; ph++) begin
            write_cap(caps[ph]);
            stall_mode = ph % 4;
            for (int n = 0; n < 155; n++) begin
                send_random();
                // sender holds off until everything has come back
                if (n == 77) begin
                    stop_sending();
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        running = 1'b0;
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/srsc_pkg.sv
rtl/core/srsc_sqrt_cell.sv
rtl/core/srsc_div_cell.sv
rtl/core/stick_radial_soft_cap.sv
tb/sv/stick_radial_soft_cap_tb.sv
